// ===== hw/rtl/mbps_pkg.sv =====
// mbps_pkg: shared types and constants for the masked byte pattern scanner
// no dependencies; imported by mbps_cell and masked_byte_pattern_scanner_unit
`default_nettype none

package mbps_pkg;

  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CareW     = 16;
  localparam int unsigned LenW      = 5;
  localparam int unsigned OffsetW   = 32;
  localparam int unsigned PatBytes  = 16;

  typedef logic [7:0] byte_t;

  typedef enum logic [CfgIndexW-1:0] {
    CFG_PAT_LOW  = 2'd0,
    CFG_PAT_HIGH = 2'd1,
    CFG_CARE     = 2'd2,
    CFG_LENGTH   = 2'd3
  } cfg_index_e;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mbps_cell.sv =====
// mbps_cell: one window byte of the scanner chain and its masked compare
// depends on mbps_pkg
`default_nettype none

module mbps_cell (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire mbps_pkg::cell_ctrl_t  ctrl_i,
  input  wire mbps_pkg::byte_t       byte_i,
  input  wire mbps_pkg::byte_t       exp_byte_i,
  input  wire logic                  care_i,
  input  wire logic                  active_i,
  output mbps_pkg::byte_t            byte_o,
  output logic                       hit_o
);
  import mbps_pkg::*;

  byte_t win_d, win_q;

  always_comb begin
    win_d = win_q;
    if (ctrl_i.clear) begin
      win_d = '0;
    end else if (ctrl_i.shift) begin
      win_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else begin
      win_q <= win_d;
    end
  end

  // compare against the byte entering this cell on the current beat
  assign hit_o  = !active_i || !care_i || (byte_i == exp_byte_i);
  assign byte_o = win_q;

endmodule

`default_nettype wire

// ===== hw/rtl/masked_byte_pattern_scanner_unit.sv =====
// masked_byte_pattern_scanner_unit: top level, config registers, cell chain, result register
// depends on mbps_pkg and mbps_cell
//
// channel  direction  handshake                 payload
// in       sink       in_valid_i / in_stall_o   data_byte_i, region_end_i
// out      source     out_valid_o / out_stall_i found_o, match_offset_o
// cfg      sink       cfg_we_i                  cfg_index_i, cfg_data_i
//
// one byte per cycle while in_stall_o is low; the result of a beat is registered and shows in the cycle after it
// the compare is a combinational AND over the PATTERN_MAX cells of the window chain
// in_stall_o is high only while a result waits in the output register and is stalled
// reset clears the window, the byte count and the config registers to their defaults
`default_nettype none

module masked_byte_pattern_scanner_unit #(
  parameter int unsigned PATTERN_MAX = 16,
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [7:0]                          data_byte_i,
  input  wire logic                                region_end_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic                                     found_o,
  output logic [mbps_pkg::OffsetW-1:0]             match_offset_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [mbps_pkg::CfgIndexW-1:0]      cfg_index_i,
  input  wire logic [mbps_pkg::CfgDataW-1:0]       cfg_data_i
);
  import mbps_pkg::*;

  localparam int unsigned ExtW = (OFFSET_BITS > OffsetW) ? OFFSET_BITS : OffsetW;
  localparam logic [OFFSET_BITS-1:0] CountMax = '1;
  localparam logic [LenW-1:0] LenMax = LenW'(PATTERN_MAX);

  logic [CfgDataW-1:0] pat_low_q, pat_high_q;
  logic [CareW-1:0]    care_q;
  logic [LenW-1:0]     len_q;

  logic                   answered_d, answered_q;
  logic [OFFSET_BITS-1:0] seen_d, seen_q, seen_inc;
  logic                   out_valid_d, out_valid_q;
  logic                   found_d, found_q;
  logic [OffsetW-1:0]     offset_d, offset_q;

  logic                   in_acc;
  logic [LenW-1:0]        len_eff;
  logic [OFFSET_BITS-1:0] len_ext, diff;
  logic [ExtW-1:0]        diff_ext;
  logic                   all_hit, hit_now, miss_now;
  cell_ctrl_t             ctrl;

  byte_t                  pat_bytes [PatBytes];
  byte_t                  chain_byte [PATTERN_MAX];
  logic [PATTERN_MAX-1:0] cell_hit;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      care_q     <= '1;
      len_q      <= LenW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_PAT_LOW:  pat_low_q  <= cfg_data_i;
        CFG_PAT_HIGH: pat_high_q <= cfg_data_i;
        CFG_CARE:     care_q     <= cfg_data_i[CareW-1:0];
        CFG_LENGTH:   len_q      <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  for (genvar j = 0; j < 8; j++) begin : g_pat
    assign pat_bytes[j]     = pat_low_q[8*j +: 8];
    assign pat_bytes[j + 8] = pat_high_q[8*j +: 8];
  end

  assign len_eff    = (len_q > LenMax) ? LenMax : len_q;
  assign in_stall_o = out_valid_q && out_stall_i;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign ctrl.shift = in_acc && !answered_q;
  assign ctrl.clear = in_acc && region_end_i;

  // cell chain, cell 0 takes the newest byte
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    localparam logic [LenW-1:0] Pos = LenW'(k);
    logic [LenW-1:0] pidx;
    byte_t           cin;

    assign pidx = len_eff - Pos - LenW'(1);
    if (k == 0) begin : g_head
      assign cin = data_byte_i;
    end else begin : g_link
      assign cin = chain_byte[k-1];
    end

    mbps_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .byte_i     (cin),
      .exp_byte_i (pat_bytes[pidx[3:0]]),
      .care_i     (care_q[pidx[3:0]]),
      .active_i   (len_eff > Pos),
      .byte_o     (chain_byte[k]),
      .hit_o      (cell_hit[k])
    );
  end

  assign all_hit  = &cell_hit;
  assign seen_inc = (seen_q == CountMax) ? seen_q : seen_q + OFFSET_BITS'(1);
  assign len_ext  = OFFSET_BITS'(len_eff);
  assign diff     = seen_inc - len_ext;
  assign diff_ext = ExtW'(diff);

  assign hit_now  = (len_eff == '0) || ((seen_inc >= len_ext) && all_hit);
  assign miss_now = !hit_now && region_end_i;

  always_comb begin
    answered_d  = answered_q;
    seen_d      = seen_q;
    out_valid_d = out_valid_q;
    found_d     = found_q;
    offset_d    = offset_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (ctrl.shift) begin
      seen_d = seen_inc;
      if (hit_now) begin
        answered_d  = 1'b1;
        out_valid_d = 1'b1;
        found_d     = 1'b1;
        offset_d    = (len_eff == '0) ? '0 : diff_ext[OffsetW-1:0];
      end else if (miss_now) begin
        out_valid_d = 1'b1;
        found_d     = 1'b0;
        offset_d    = '0;
      end
    end
    if (ctrl.clear) begin
      answered_d = 1'b0;
      seen_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      answered_q  <= 1'b0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      answered_q  <= answered_d;
      seen_q      <= seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q  <= found_d;
    offset_q <= offset_d;
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign match_offset_o = offset_q;

  a_result_from_beat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_acc))
    else $error("result appeared without an accepted beat");

  a_miss_offset_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !found_q) |-> (offset_q == '0))
    else $error("not-found result with non-zero offset");

  a_region_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && region_end_i) |=> (!answered_q && (seen_q == '0)))
    else $error("state not cleared after last beat of region");

  a_count_monotonic : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !region_end_i) |=> (seen_q >= $past(seen_q)))
    else $error("byte count went backwards within a region");

endmodule

`default_nettype wire
